// ===== hdl/scgc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the stereo matching cost block.
package scgc_pkg;

  // Default sizing
  localparam int DEF_MAX_ROW_WIDTH   = 4096;
  localparam int DEF_MAX_DISPARITIES = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISPARITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPARITY_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH       = 2'd2;

  localparam logic [11:0] RST_MIN_DISPARITY   = 12'd0;
  localparam logic [5:0]  RST_DISPARITY_COUNT = 6'd32;
  localparam logic [12:0] RST_ROW_WIDTH       = 13'd640;

  // Gray weights, Q10
  localparam int GRAY_WR = 306;
  localparam int GRAY_WG = 601;
  localparam int GRAY_WB = 117;
  localparam int GRAY_W  = 18;

  // Gradient offsets: 127.5 at the one-sided and two-sided scale
  localparam logic signed [19:0] GRAD_EDGE_OFS = 20'sd130560;
  localparam logic [19:0]        GRAD_MID_OFS  = 20'd261120;
  localparam logic [7:0]         GRAD_SINGLE   = 8'd127;

  // Cost caps
  localparam logic [9:0] COLOR_SUM_CAP  = 10'd30;
  localparam logic [7:0] COLOR_COST_CAP = 8'd170;
  localparam logic [7:0] GRAD_DIFF_CAP  = 8'd5;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } scgc_rgb_t;

  // One row store word: target color and its x-gradient
  typedef struct packed {
    logic [7:0] grad;
    scgc_rgb_t  rgb;
  } scgc_entry_t;

  function automatic logic [GRAY_W-1:0] gray_q10(input scgc_rgb_t p);
    logic [GRAY_W-1:0] acc;
    acc = GRAY_W'(GRAY_WR) * GRAY_W'(p.red)
        + GRAY_W'(GRAY_WG) * GRAY_W'(p.green)
        + GRAY_W'(GRAY_WB) * GRAY_W'(p.blue);
    return acc;
  endfunction

  // One-sided gradient at a row end, saturated to 0..255
  function automatic logic [7:0] grad_edge(input logic [GRAY_W-1:0] a,
                                           input logic [GRAY_W-1:0] b);
    logic signed [19:0] v;
    logic [9:0]         t;
    v = $signed({2'b00, b}) - $signed({2'b00, a}) + GRAD_EDGE_OFS;
    t = v[19:10];
    if (v < 0) begin
      return 8'd0;
    end else if (t > 10'd255) begin
      return 8'd255;
    end else begin
      return t[7:0];
    end
  endfunction

  // Central gradient, always inside 0..255
  function automatic logic [7:0] grad_mid(input logic [GRAY_W-1:0] prev,
                                          input logic [GRAY_W-1:0] next);
    logic [19:0] t;
    t = {2'b00, next} + GRAD_MID_OFS - {2'b00, prev};
    return t[18:11];
  endfunction

  // floor(17 * s / 3) for a color difference sum below the cap
  function automatic logic [7:0] color_cost(input logic [4:0] s);
    logic [7:0] c;
    case (s)
      5'd0:  c = 8'd0;
      5'd1:  c = 8'd5;
      5'd2:  c = 8'd11;
      5'd3:  c = 8'd17;
      5'd4:  c = 8'd22;
      5'd5:  c = 8'd28;
      5'd6:  c = 8'd34;
      5'd7:  c = 8'd39;
      5'd8:  c = 8'd45;
      5'd9:  c = 8'd51;
      5'd10: c = 8'd56;
      5'd11: c = 8'd62;
      5'd12: c = 8'd68;
      5'd13: c = 8'd73;
      5'd14: c = 8'd79;
      5'd15: c = 8'd85;
      5'd16: c = 8'd90;
      5'd17: c = 8'd96;
      5'd18: c = 8'd102;
      5'd19: c = 8'd107;
      5'd20: c = 8'd113;
      5'd21: c = 8'd119;
      5'd22: c = 8'd124;
      5'd23: c = 8'd130;
      5'd24: c = 8'd136;
      5'd25: c = 8'd141;
      5'd26: c = 8'd147;
      5'd27: c = 8'd153;
      5'd28: c = 8'd158;
      5'd29: c = 8'd164;
      default: c = COLOR_COST_CAP;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/scgc_cost.sv =====
// Shared cost unit: truncated color difference plus truncated gradient difference.
module scgc_cost (
  input  scgc_pkg::scgc_rgb_t   ref_rgb,
  input  logic [7:0]            ref_grad,
  input  scgc_pkg::scgc_entry_t entry,
  output logic [7:0]            cost
);

  logic [7:0] diff_r;
  logic [7:0] diff_g;
  logic [7:0] diff_b;
  logic [7:0] diff_grad;
  logic [9:0] color_sum;
  logic [2:0] grad_term;
  logic [7:0] color_term;

  // Absolute channel and gradient differences, and the color difference sum
  always_comb begin
    diff_r    = (ref_rgb.red > entry.rgb.red) ? ref_rgb.red - entry.rgb.red
                                              : entry.rgb.red - ref_rgb.red;
    diff_g    = (ref_rgb.green > entry.rgb.green) ? ref_rgb.green - entry.rgb.green
                                                  : entry.rgb.green - ref_rgb.green;
    diff_b    = (ref_rgb.blue > entry.rgb.blue) ? ref_rgb.blue - entry.rgb.blue
                                                : entry.rgb.blue - ref_rgb.blue;
    diff_grad = (ref_grad > entry.grad) ? ref_grad - entry.grad : entry.grad - ref_grad;
    color_sum = 10'(diff_r) + 10'(diff_g) + 10'(diff_b);
  end

  // Cap both terms; the 17/3 scale of the color term comes from a table
  always_comb begin
    if (diff_grad > scgc_pkg::GRAD_DIFF_CAP) begin
      grad_term = 3'(scgc_pkg::GRAD_DIFF_CAP);
    end else begin
      grad_term = diff_grad[2:0];
    end
    if (color_sum >= scgc_pkg::COLOR_SUM_CAP) begin
      color_term = scgc_pkg::COLOR_COST_CAP;
    end else begin
      color_term = scgc_pkg::color_cost(color_sum[4:0]);
    end
    cost = color_term + {1'b0, grad_term, 4'b0000} + 8'(grad_term);
  end

endmodule

// ===== hdl/stereo_color_gradient_cost_top.sv =====
// A pixel's first cost leaves after the next pixel is accepted.
// Throughput: one cost per cycle while out_stall is low; the input stalls until a request is done.
// A row-end request also flushes its own pixel: the input stays stalled until its costs are issued too.
// Rate is set by the single read port of the row store feeding the shared cost unit.
// Reset (synchronous, active low) clears control and histories, sets configuration to defaults;
// the row store is not cleared and is always written before it is read.
module stereo_color_gradient_cost_top #(
  parameter int MAX_ROW_WIDTH   = scgc_pkg::DEF_MAX_ROW_WIDTH,
  parameter int MAX_DISPARITIES = scgc_pkg::DEF_MAX_DISPARITIES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration
  input  logic                             cfg_we,
  input  logic [scgc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [scgc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // Input pixels
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_ref_red,
  input  logic [7:0]                       in_ref_green,
  input  logic [7:0]                       in_ref_blue,
  input  logic [7:0]                       in_tgt_red,
  input  logic [7:0]                       in_tgt_green,
  input  logic [7:0]                       in_tgt_blue,
  input  logic                             in_row_end,
  // Costs
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [11:0]                      out_pixel_x,
  output logic [4:0]                       out_disparity_index,
  output logic [7:0]                       out_cost_value,
  output logic                             out_last_of_run
);

  localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int CW = (AW + 1 > 13) ? AW + 1 : 13;
  localparam int DW = $clog2(MAX_DISPARITIES + 1);
  localparam int GW = scgc_pkg::GRAY_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GRAY = 3'd1;
  localparam logic [2:0] S_GRAD = 3'd2;
  localparam logic [2:0] S_WRP  = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;
  localparam logic [2:0] S_WRC  = 3'd5;

  // Configuration registers
  logic [11:0] min_disp_r;
  logic [5:0]  disp_cnt_r;
  logic [12:0] row_width_r;

  // Sequencer and row state
  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       col_r;
  logic [GW-1:0]       rhist_prev_r, rhist_cur_r, thist_prev_r, thist_cur_r;
  scgc_pkg::scgc_rgb_t held_ref_r, held_tgt_r;

  // Current request
  logic [AW-1:0]       it_col_r;
  scgc_pkg::scgc_rgb_t it_ref_r, it_tgt_r;
  logic                it_row_end_r;
  logic                it_end_r;
  logic [GW-1:0]       rg_r, tg_r;
  logic [7:0]          tgrad_p_r, rgrad_p_r, tgrad_c_r, rgrad_c_r;

  // Disparity run
  logic [AW-1:0]       run_x_r;
  scgc_pkg::scgc_rgb_t run_rgb_r;
  logic [7:0]          run_grad_r;
  logic                run_final_r;
  logic [DW-1:0]       d_issue_r;
  logic [DW-1:0]       run_cnt;

  // Row store and read stage
  scgc_pkg::scgc_entry_t store_mem [MAX_ROW_WIDTH];
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  scgc_pkg::scgc_entry_t wr_data;
  logic [AW-1:0]         rd_addr;
  scgc_pkg::scgc_entry_t rd_data_r;
  logic                  rd_pend_r;
  logic [DW-1:0]         rd_d_r;
  logic                  rd_last_r;

  // Output register
  logic        out_valid_r;
  logic [11:0] out_x_r;
  logic [4:0]  out_d_r;
  logic [7:0]  out_cost_r;
  logic        out_last_r;

  logic          in_accept;
  logic          issue;
  logic          load_out;
  logic          run_done;
  logic          end_now;
  logic [12:0]   disp;
  logic [CW-1:0] tx;
  logic [7:0]    cost;
  logic [7:0]    t_edge, r_edge;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // Effective disparity count
  always_comb begin
    if (disp_cnt_r == 6'd0) begin
      run_cnt = DW'(1);
    end else if (disp_cnt_r > 6'(MAX_DISPARITIES)) begin
      run_cnt = DW'(MAX_DISPARITIES);
    end else begin
      run_cnt = DW'(disp_cnt_r);
    end
  end

  // Read issue and output hand-off
  assign load_out = rd_pend_r && (!out_valid_r || !out_stall);
  assign issue    = (state_r == S_RUN) && (d_issue_r != run_cnt) && (!rd_pend_r || load_out);
  assign run_done = (state_r == S_RUN) && (d_issue_r == run_cnt) && !rd_pend_r;

  // Target column, clamped at zero
  always_comb begin
    disp = 13'(min_disp_r) + 13'(d_issue_r);
    if (CW'(run_x_r) >= CW'(disp)) begin
      tx = CW'(run_x_r) - CW'(disp);
    end else begin
      tx = '0;
    end
    rd_addr = tx[AW-1:0];
  end

  // Row end by flag, by row width or by store depth
  assign end_now = it_row_end_r
                || (CW'(it_col_r) + CW'(1) >= CW'(row_width_r))
                || (CW'(it_col_r) + CW'(1) >= CW'(MAX_ROW_WIDTH));

  // One-sided gradients, shared by the first and the last pixel of a row
  assign t_edge = scgc_pkg::grad_edge(thist_cur_r, tg_r);
  assign r_edge = scgc_pkg::grad_edge(rhist_cur_r, rg_r);

  // Row store writes: finished pixel, then the row-end pixel
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = it_col_r;
    wr_data = {tgrad_c_r, it_tgt_r};
    if (state_r == S_WRP && it_col_r != '0) begin
      wr_en   = 1'b1;
      wr_addr = it_col_r - AW'(1);
      wr_data = {tgrad_p_r, held_tgt_r};
    end else if (state_r == S_WRC) begin
      wr_en = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_GRAY;
      S_GRAY: state_nxt = S_GRAD;
      S_GRAD: state_nxt = S_WRP;
      S_WRP: begin
        if (it_col_r != '0) begin
          state_nxt = S_RUN;
        end else if (it_end_r) begin
          state_nxt = S_WRC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RUN: begin
        if (run_done) begin
          state_nxt = run_final_r ? S_IDLE : S_WRC;
        end
      end
      S_WRC:   state_nxt = S_RUN;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and row state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      min_disp_r   <= scgc_pkg::RST_MIN_DISPARITY;
      disp_cnt_r   <= scgc_pkg::RST_DISPARITY_COUNT;
      row_width_r  <= scgc_pkg::RST_ROW_WIDTH;
      col_r        <= '0;
      rhist_prev_r <= '0;
      rhist_cur_r  <= '0;
      thist_prev_r <= '0;
      thist_cur_r  <= '0;
      held_ref_r   <= '0;
      held_tgt_r   <= '0;
      d_issue_r    <= '0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes
      if (cfg_we) begin
        case (cfg_index)
          scgc_pkg::CFG_MIN_DISPARITY:   min_disp_r  <= cfg_wdata[11:0];
          scgc_pkg::CFG_DISPARITY_COUNT: disp_cnt_r  <= cfg_wdata[5:0];
          scgc_pkg::CFG_ROW_WIDTH:       row_width_r <= cfg_wdata[12:0];
          default: ;
        endcase
      end

      // Advance the row once gradients are taken, or restart it after a row end
      if (state_r == S_WRP) begin
        if (it_end_r) begin
          col_r        <= '0;
          rhist_prev_r <= '0;
          rhist_cur_r  <= '0;
          thist_prev_r <= '0;
          thist_cur_r  <= '0;
          held_ref_r   <= '0;
          held_tgt_r   <= '0;
        end else begin
          col_r        <= it_col_r + AW'(1);
          rhist_prev_r <= rhist_cur_r;
          rhist_cur_r  <= rg_r;
          thist_prev_r <= thist_cur_r;
          thist_cur_r  <= tg_r;
          held_ref_r   <= it_ref_r;
          held_tgt_r   <= it_tgt_r;
        end
      end

      // Disparity counter
      if (state_r == S_WRP || state_r == S_WRC) begin
        d_issue_r <= '0;
      end else if (issue) begin
        d_issue_r <= d_issue_r + DW'(1);
      end

      // Read stage occupancy
      if (issue) begin
        rd_pend_r <= 1'b1;
      end else if (load_out) begin
        rd_pend_r <= 1'b0;
      end

      // Output register occupancy
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request payload, gray values and gradients
  always_ff @(posedge clk) begin
    if (in_accept) begin
      it_col_r     <= col_r;
      it_ref_r     <= '{blue: in_ref_blue, green: in_ref_green, red: in_ref_red};
      it_tgt_r     <= '{blue: in_tgt_blue, green: in_tgt_green, red: in_tgt_red};
      it_row_end_r <= in_row_end;
    end
    if (state_r == S_GRAY) begin
      rg_r     <= scgc_pkg::gray_q10(it_ref_r);
      tg_r     <= scgc_pkg::gray_q10(it_tgt_r);
      it_end_r <= end_now;
    end
    if (state_r == S_GRAD) begin
      if (it_col_r == AW'(1)) begin
        tgrad_p_r <= t_edge;
        rgrad_p_r <= r_edge;
      end else begin
        tgrad_p_r <= scgc_pkg::grad_mid(thist_prev_r, tg_r);
        rgrad_p_r <= scgc_pkg::grad_mid(rhist_prev_r, rg_r);
      end
      if (it_col_r == '0) begin
        tgrad_c_r <= scgc_pkg::GRAD_SINGLE;
        rgrad_c_r <= scgc_pkg::GRAD_SINGLE;
      end else begin
        tgrad_c_r <= t_edge;
        rgrad_c_r <= r_edge;
      end
    end
  end

  // Set up a run for the finished pixel or the row-end pixel
  always_ff @(posedge clk) begin
    if (state_r == S_WRP) begin
      run_x_r     <= it_col_r - AW'(1);
      run_rgb_r   <= held_ref_r;
      run_grad_r  <= rgrad_p_r;
      run_final_r <= !it_end_r;
    end else if (state_r == S_WRC) begin
      run_x_r     <= it_col_r;
      run_rgb_r   <= it_ref_r;
      run_grad_r  <= rgrad_c_r;
      run_final_r <= 1'b1;
    end
  end

  // Row store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= store_mem[rd_addr];
      rd_d_r    <= d_issue_r;
      rd_last_r <= run_final_r && (d_issue_r == run_cnt - DW'(1));
    end
  end

  scgc_cost u_cost (
    .ref_rgb  (run_rgb_r),
    .ref_grad (run_grad_r),
    .entry    (rd_data_r),
    .cost     (cost)
  );

  // Output payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r    <= 12'(run_x_r);
      out_d_r    <= 5'(rd_d_r);
      out_cost_r <= cost;
      out_last_r <= rd_last_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_x         = out_x_r;
  assign out_disparity_index = out_d_r;
  assign out_cost_value      = out_cost_r;
  assign out_last_of_run     = out_last_r;

`ifndef SYNTHESIS
  // Disparity counter stays within the run length
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> d_issue_r <= run_cnt)
    else $error("disparity counter ran past the run length");

  // No read result is left behind when the block turns ready
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !rd_pend_r)
    else $error("read stage still occupied while idle");

  // The last cost of a request closes the request
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && rd_last_r |=> ##1 state_r == S_IDLE)
    else $error("request did not finish after its last cost");

  // Reads are only issued inside a run
  a_issue_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> !wr_en && state_r == S_RUN)
    else $error("row store read issued outside a run");
`endif

endmodule
